// ===== hdl/tmlm_pkg.sv =====
// Shared types and constants for the trimmed-mean level meter.
`timescale 1ns / 1ps

package tmlm_pkg;

    localparam int LEVEL_COUNT = 6;
    localparam int THR_W       = 12;
    localparam int MEAN_W      = 12;
    localparam int BAR_W       = LEVEL_COUNT;
    localparam int LVL_IDX_W   = 3;

    typedef logic [THR_W-1:0] t_thr;

    localparam t_thr THR_RESET [LEVEL_COUNT] = '{
        12'd1500, 12'd2000, 12'd2500, 12'd3000, 12'd3500, 12'd4000
    };

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

endpackage

// ===== hdl/trimmed_mean_level_meter.sv =====
// Trimmed-mean level meter: frame accumulator, shared add/subtract unit and level bar.
`timescale 1ns / 1ps

// A sample that closes a frame shows its result after add, min compare, max compare,
//   two trims, reciprocal multiply, six level compares and output load.
// Each sample passes accept, add, min compare and max compare on the shared add/subtract
//   unit before the next is taken; a frame-closing sample keeps the input off until its
//   result moves into the output register, which waits while a previous result is held.
// Reset: synchronous, active low; clears the frame and loads default thresholds.
module trimmed_mean_level_meter #(
    parameter int WINDOW      = 12,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // sample channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [SAMPLE_BITS-1:0]               i_sample,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [tmlm_pkg::MEAN_W-1:0]          o_mean_value,
    output logic [tmlm_pkg::BAR_W-1:0]           o_level_bar,
    // threshold write port
    input  logic                                 i_cfg_wr_en,
    input  logic [tmlm_pkg::LVL_IDX_W-1:0]       i_cfg_index,
    input  logic [tmlm_pkg::THR_W-1:0]           i_cfg_wdata
);

    // Widths follow from the frame size and sample width.
    localparam int MAX_SUM = WINDOW * ((1 << SAMPLE_BITS) - 1);
    localparam int SUM_W   = $clog2(MAX_SUM + 1);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int DIVISOR = WINDOW - 2;
    localparam int ALU_W   = (SUM_W > tmlm_pkg::THR_W) ? SUM_W : tmlm_pkg::THR_W;
    localparam int EXT_W   = (SAMPLE_BITS > tmlm_pkg::MEAN_W) ? SAMPLE_BITS
                                                              : tmlm_pkg::MEAN_W;

    // Reciprocal of the divisor, rounded up, exact for every SUM_W-bit dividend.
    localparam int                 RCP_SH  = SUM_W + $clog2(DIVISOR);
    localparam int                 RCP_W   = SUM_W + 1;
    localparam int                 PROD_W  = SUM_W + RCP_W;
    localparam longint             RCP_ONE = longint'(1) << RCP_SH;
    localparam logic [RCP_W-1:0]   RCP_MUL = RCP_W'((RCP_ONE + DIVISOR - 1) / DIVISOR);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_MIN,
        S_MAX,
        S_TRIM_MIN,
        S_TRIM_MAX,
        S_DIV,
        S_CMP,
        S_OUT
    } t_state;

    t_state                           r_state;
    logic [SAMPLE_BITS-1:0]           r_sample;
    logic [CNT_W-1:0]                 r_cnt;
    logic [SUM_W-1:0]                 r_sum;   // running sum, then trimmed sum, then mean
    logic [SAMPLE_BITS-1:0]           r_min;
    logic [SAMPLE_BITS-1:0]           r_max;
    logic [tmlm_pkg::LVL_IDX_W-1:0]   r_lvl;
    logic [tmlm_pkg::BAR_W-1:0]       r_bar;
    tmlm_pkg::t_thr                   r_thr [tmlm_pkg::LEVEL_COUNT];
    logic                             r_out_valid;
    logic [tmlm_pkg::MEAN_W-1:0]      r_out_mean;
    logic [tmlm_pkg::BAR_W-1:0]       r_out_bar;

    // Shared add/subtract unit; the top result bit is the borrow on a subtract.
    tmlm_pkg::t_alu_op                alu_op;
    logic [ALU_W-1:0]                 alu_a;
    logic [ALU_W-1:0]                 alu_b;
    logic [ALU_W:0]                   alu_res;
    logic                             alu_borrow;

    logic [PROD_W-1:0]                rcp_prod;
    logic [SUM_W-1:0]                 rcp_quot;
    logic [EXT_W-1:0]                 mean_ext;
    logic                             out_load;

    // Divide the trimmed sum by the constant divisor with one reciprocal multiply.
    assign rcp_prod = PROD_W'(r_sum) * PROD_W'(RCP_MUL);
    assign rcp_quot = SUM_W'(rcp_prod >> RCP_SH);

    // Move a finished result into the output register when it is free or being taken.
    assign out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        alu_op = tmlm_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (r_state)
            S_ADD: begin
                alu_op = tmlm_pkg::ALU_ADD;
                alu_a  = ALU_W'(r_sum);
                alu_b  = ALU_W'(r_sample);
            end
            S_MIN: begin
                // borrow means sample < min
                alu_op = tmlm_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_sample);
                alu_b  = ALU_W'(r_min);
            end
            S_MAX: begin
                // borrow means sample > max
                alu_op = tmlm_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_max);
                alu_b  = ALU_W'(r_sample);
            end
            S_TRIM_MIN: begin
                alu_op = tmlm_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_sum);
                alu_b  = ALU_W'(r_min);
            end
            S_TRIM_MAX: begin
                alu_op = tmlm_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_sum);
                alu_b  = ALU_W'(r_max);
            end
            S_CMP: begin
                // borrow means mean > threshold
                alu_op = tmlm_pkg::ALU_SUB;
                alu_a  = ALU_W'(r_thr[r_lvl]);
                alu_b  = ALU_W'(r_sum[SAMPLE_BITS-1:0]);
            end
            default: begin
                alu_op = tmlm_pkg::ALU_ADD;
            end
        endcase
    end

    always_comb begin
        if (alu_op == tmlm_pkg::ALU_SUB) begin
            alu_res = {1'b0, alu_a} - {1'b0, alu_b};
        end else begin
            alu_res = {1'b0, alu_a} + {1'b0, alu_b};
        end
    end

    assign alu_borrow = alu_res[ALU_W];

    // Sequencer: frame accumulation, trim, reciprocal divide, level compares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_min       <= '1;
            r_max       <= '0;
            r_lvl       <= '0;
            r_bar       <= '0;
            r_out_valid <= 1'b0;
            r_out_mean  <= '0;
            r_out_bar   <= '0;
            for (int k = 0; k < tmlm_pkg::LEVEL_COUNT; k++) begin
                r_thr[k] <= tmlm_pkg::THR_RESET[k];
            end
        end else begin
            // Threshold writes; indexes past the last level are dropped.
            if (i_cfg_wr_en &&
                (i_cfg_index < tmlm_pkg::LVL_IDX_W'(tmlm_pkg::LEVEL_COUNT))) begin
                r_thr[i_cfg_index] <= i_cfg_wdata;
            end

            // Output register: load a finished result, drop valid once taken.
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_mean  <= mean_ext[tmlm_pkg::MEAN_W-1:0];
                r_out_bar   <= r_bar;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_sample <= i_sample;
                        r_state  <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_sum   <= alu_res[SUM_W-1:0];
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    if (alu_borrow) begin
                        r_min <= r_sample;
                    end
                    r_state <= S_MAX;
                end
                S_MAX: begin
                    if (alu_borrow) begin
                        r_max <= r_sample;
                    end
                    if (r_cnt == CNT_W'(WINDOW - 1)) begin
                        r_state <= S_TRIM_MIN;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_TRIM_MIN: begin
                    r_sum   <= alu_res[SUM_W-1:0];
                    r_state <= S_TRIM_MAX;
                end
                S_TRIM_MAX: begin
                    r_sum   <= alu_res[SUM_W-1:0];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_sum   <= rcp_quot;
                    r_lvl   <= '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_bar[r_lvl] <= alu_borrow;
                    if (r_lvl == tmlm_pkg::LVL_IDX_W'(tmlm_pkg::LEVEL_COUNT - 1)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_OUT: begin
                    // Hold until the output register takes the result, then restart.
                    if (out_load) begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_min   <= '1;
                        r_max   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The quotient fits SAMPLE_BITS; resize it to the mean field.
    assign mean_ext     = EXT_W'(r_sum[SAMPLE_BITS-1:0]);
    assign o_mean_value = r_out_mean;
    assign o_level_bar  = r_out_bar;
    assign o_out_valid  = r_out_valid;
    assign o_in_stall   = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_mean_value) && $stable(o_level_bar)))
        else $error("stalled result transaction changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer did not go busy after a sample transaction");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(WINDOW))
        else $error("frame count beyond window");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_cnt != '0) |-> (r_min <= r_max))
        else $error("frame minimum above frame maximum");

    a_out_after_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised without finishing the level compares");
`endif

endmodule

// ===== test/trimmed_mean_level_meter_test.sv =====
// Self-checking testbench for the trimmed-mean level meter with a frame-level scoreboard.
`timescale 1ns / 1ps

module trimmed_mean_level_meter_test;

    // Block geometry at its default parameters.
    localparam int WINDOW      = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

    // Settling time after the last expected result, before the next register write.
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_TAIL   = 60;

    // Threshold register map; the two spare indexes must be ignored by the block.
    localparam logic [tmlm_pkg::LVL_IDX_W-1:0] IDX_LEVEL1 = 3'd0;
    localparam logic [tmlm_pkg::LVL_IDX_W-1:0] IDX_SPARE6 = 3'd6;
    localparam logic [tmlm_pkg::LVL_IDX_W-1:0] IDX_SPARE7 = 3'd7;

    typedef struct packed {
        logic [tmlm_pkg::MEAN_W-1:0] mean;
        logic [tmlm_pkg::BAR_W-1:0]  bar;
    } t_meter_result;

    typedef enum int {
        STYLE_RANDOM,
        STYLE_CLUSTER,
        STYLE_FLAT,
        STYLE_SPIKY
    } t_frame_style;

    typedef enum int {
        PLAN_ZERO,
        PLAN_FULL,
        PLAN_DEFAULT,
        PLAN_LADDER,
        PLAN_RANDOM
    } t_level_plan;

    // Frame accumulator and expected-result store.
    class level_meter_scoreboard;
        tmlm_pkg::t_thr  level_thr [tmlm_pkg::LEVEL_COUNT];
        int unsigned     frame_taken;
        int unsigned     frame_sum;
        int unsigned     frame_lo;
        int unsigned     frame_hi;
        t_meter_result   expected_q [$];
        int unsigned     errors;

        function new();
            for (int k = 0; k < tmlm_pkg::LEVEL_COUNT; k++) begin
                level_thr[k] = tmlm_pkg::THR_RESET[k];
            end
            errors = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            frame_taken = 0;
            frame_sum   = 0;
            frame_lo    = SAMPLE_MAX;
            frame_hi    = 0;
        endfunction

        function void write_threshold(logic [tmlm_pkg::LVL_IDX_W-1:0] idx,
                                      tmlm_pkg::t_thr value);
            if (idx < tmlm_pkg::LEVEL_COUNT) begin
                level_thr[idx] = value;
            end
        endfunction

        // Accumulate one accepted sample; close the frame on the last one.
        function void note_sample(logic [SAMPLE_BITS-1:0] value);
            t_meter_result res;
            int unsigned   avg;
            int unsigned   s;
            s = 32'(value);
            frame_sum += s;
            if (s < frame_lo) begin
                frame_lo = s;
            end
            if (s > frame_hi) begin
                frame_hi = s;
            end
            frame_taken++;
            if (frame_taken == WINDOW) begin
                // Drop one smallest and one largest sample, then truncate.
                avg      = (frame_sum - frame_lo - frame_hi) / (WINDOW - 2);
                res.mean = avg[tmlm_pkg::MEAN_W-1:0];
                for (int k = 0; k < tmlm_pkg::LEVEL_COUNT; k++) begin
                    res.bar[k] = (res.mean > level_thr[k]);
                end
                expected_q.push_back(res);
                restart_frame();
            end
        endfunction

        function void check_result(logic [tmlm_pkg::MEAN_W-1:0] mean,
                                   logic [tmlm_pkg::BAR_W-1:0] bar);
            t_meter_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, mean_value %0d level_bar %b",
                         $time, mean, bar);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (mean !== want.mean) begin
                $display("%0t: mean_value expected %0d actual %0d", $time, want.mean, mean);
                errors++;
            end
            if (bar !== want.bar) begin
                $display("%0t: level_bar expected %b actual %b", $time, want.bar, bar);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    logic [SAMPLE_BITS-1:0]            i_sample;
    logic                              o_out_valid;
    logic                              i_out_stall;
    logic [tmlm_pkg::MEAN_W-1:0]       o_mean_value;
    logic [tmlm_pkg::BAR_W-1:0]        o_level_bar;
    logic                              i_cfg_wr_en;
    logic [tmlm_pkg::LVL_IDX_W-1:0]    i_cfg_index;
    logic [tmlm_pkg::THR_W-1:0]        i_cfg_wdata;

    level_meter_scoreboard meter = new();
    bit                    quiet_tail = 1'b0;

    trimmed_mean_level_meter #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mean_value (o_mean_value),
        .o_level_bar  (o_level_bar),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Observe every handshake on the edge: register writes and accepted samples
    // feed the predictor, accepted results are checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                meter.write_threshold(i_cfg_index, i_cfg_wdata);
            end
            if (i_in_valid && !o_in_stall) begin
                meter.note_sample(i_sample);
            end
            if (o_out_valid && !i_out_stall) begin
                meter.check_result(o_mean_value, o_level_bar);
            end
        end
    end

    // Result side back-pressure: stall and free bursts of random length, each burst stalled
    // with a chance of one in three; hold stall low once the quiet tail starts.
    initial begin
        forever begin
            i_out_stall <= !quiet_tail && ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 17)) begin
                @(posedge i_clk);
                if (quiet_tail) break;
            end
        end
    end

    // Present one sample and hold it until the block takes the transaction.
    // Insert an occasional idle burst first, except in the quiet tail.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Leave the write enable high; the caller drops it after the last write.
    task automatic write_reg(input logic [tmlm_pkg::LVL_IDX_W-1:0] idx,
                             input tmlm_pkg::t_thr value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // Drop valid, let the monitor see the last transaction, drain every expected
    // result, then let the block settle before the next register write.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (meter.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Rewrite all six thresholds, plus a write to a spare index that must be ignored.
    task automatic program_levels(input t_level_plan plan);
        tmlm_pkg::t_thr value;
        int             step;
        step = $urandom_range(0, 600);
        for (int k = 0; k < tmlm_pkg::LEVEL_COUNT; k++) begin
            case (plan)
                PLAN_ZERO:    value = '0;
                PLAN_FULL:    value = '1;
                PLAN_DEFAULT: value = tmlm_pkg::THR_RESET[k];
                PLAN_LADDER: begin
                    value = (step > SAMPLE_MAX) ? tmlm_pkg::t_thr'(SAMPLE_MAX)
                                                : tmlm_pkg::t_thr'(step);
                    step += $urandom_range(0, 700);
                end
                default:      value = tmlm_pkg::t_thr'($urandom_range(0, SAMPLE_MAX));
            endcase
            write_reg(IDX_LEVEL1 + tmlm_pkg::LVL_IDX_W'(k), value);
        end
        write_reg(($urandom_range(0, 1) == 0) ? IDX_SPARE6 : IDX_SPARE7,
                  tmlm_pkg::t_thr'($urandom_range(0, SAMPLE_MAX)));
        i_cfg_wr_en <= 1'b0;
    endtask

    // Draw one sample in the given frame style around a center value.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(t_frame_style style, int center);
        int value;
        case (style)
            STYLE_FLAT:    value = center;
            STYLE_CLUSTER: value = center + int'($urandom_range(0, 64)) - 32;
            STYLE_SPIKY: begin
                if ($urandom_range(0, 3) == 0) begin
                    value = ($urandom_range(0, 1) == 0) ? 0 : SAMPLE_MAX;
                end else begin
                    value = center + int'($urandom_range(0, 16)) - 8;
                end
            end
            default:       value = $urandom_range(0, SAMPLE_MAX);
        endcase
        if (value < 0) begin
            value = 0;
        end
        if (value > SAMPLE_MAX) begin
            value = SAMPLE_MAX;
        end
        return value[SAMPLE_BITS-1:0];
    endfunction

    initial begin : stimulus
        t_frame_style style;
        int           center;
        int           sent;
        int           phase_len;
        int           phase;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample    <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_wdata <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full-scale frame under reset thresholds: equal extremes, mean at the top,
        // every bar bit lit.
        repeat (WINDOW) send_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);

        // Half a frame of zeros, then move level 1 down to zero mid-frame and poke
        // a spare index; the frame must close with the new threshold.
        repeat (WINDOW / 2) send_sample('0);
        wait_idle();
        write_reg(IDX_LEVEL1, '0);
        write_reg(IDX_SPARE7, tmlm_pkg::t_thr'(123));
        i_cfg_wr_en <= 1'b0;
        // One full-scale sample is trimmed off as the maximum: mean equals level 1,
        // so its bit must stay clear.
        repeat (WINDOW / 2 - 1) send_sample('0);
        send_sample(SAMPLE_MAX[SAMPLE_BITS-1:0]);
        wait_idle();

        // Random phases, each under its own threshold plan. Phase boundaries fall
        // anywhere inside a frame, so thresholds also change mid-frame. The quiet
        // tail runs as one unbroken phase.
        sent  = 0;
        phase = 0;
        style = STYLE_RANDOM;
        center = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0:       program_levels(PLAN_ZERO);
                1:       program_levels(PLAN_FULL);
                2:       program_levels(PLAN_DEFAULT);
                default: program_levels(($urandom_range(0, 1) == 0) ? PLAN_LADDER
                                                                    : PLAN_RANDOM);
            endcase
            phase_len = $urandom_range(30, 80);
            for (int n = 0; (n < phase_len || quiet_tail) && sent < RANDOM_ITEMS; n++) begin
                // Change the frame style about once per frame; aim the center at a
                // live threshold half of the time to exercise the bar edges.
                if (sent % WINDOW == 0) begin
                    style = t_frame_style'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 0) begin
                        center = int'(meter.level_thr[$urandom_range(0,
                                                          tmlm_pkg::LEVEL_COUNT - 1)]);
                    end else begin
                        center = $urandom_range(0, SAMPLE_MAX);
                    end
                end
                if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                    quiet_tail = 1'b1;
                end
                send_sample(pick_sample(style, center));
                sent++;
            end
            wait_idle();
            phase++;
        end

        if (meter.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, meter.pending());
        end
        if (meter.errors == 0 && meter.pending() == 0) begin
            $display("trimmed_mean_level_meter_test OK");
        end else begin
            $display("trimmed_mean_level_meter_test NOT OK");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #3_000_000;
        $display("%0t: timeout", $time);
        $display("trimmed_mean_level_meter_test NOT OK");
        $finish;
    end

endmodule
